// ===== hdl/gtfu_pkg.sv =====
// ----------------------------------------------------------------------------
// gtfu_pkg
// shared codes, reset values and bundle types of the gap-timed frame buffer
// ----------------------------------------------------------------------------
`default_nettype none

package gtfu_pkg;

	localparam int RX_DEPTH_DEFAULT = 64;

	// command codes
	localparam logic [2:0] CMD_RX_BYTE    = 3'd0;
	localparam logic [2:0] CMD_TICK       = 3'd1;
	localparam logic [2:0] CMD_LINE_ERROR = 3'd2;
	localparam logic [2:0] CMD_SCAN       = 3'd3;
	localparam logic [2:0] CMD_READ_FRAME = 3'd4;
	localparam logic [2:0] CMD_START_TX   = 3'd5;
	localparam logic [2:0] CMD_TX_EMPTY   = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_NOT_READY    = 2'd1;
	localparam logic [1:0] ST_TRANSMITTING = 2'd2;
	localparam logic [1:0] ST_BAD_PARAM    = 2'd3;

	// receive states
	localparam logic [1:0] RS_IDLE     = 2'd0;
	localparam logic [1:0] RS_BUSY     = 2'd1;
	localparam logic [1:0] RS_COMPLETE = 2'd2;
	localparam logic [1:0] RS_READY    = 2'd3;

	// configuration register indexes and reset values
	localparam logic CFG_CHAR_GAP = 1'b0;
	localparam logic CFG_HOLDOFF  = 1'b1;
	localparam logic [7:0] CHAR_GAP_RESET = 8'd5;
	localparam logic [7:0] HOLDOFF_RESET  = 8'd10;

	// command into the transmit sequencer
	typedef struct packed {
		logic        fire;
		logic [2:0]  command;
		logic [15:0] tx_length;
	} tx_cmd_t;

	// answer of the transmit sequencer
	typedef struct packed {
		logic [1:0]  status;
		logic        send_valid;
		logic [15:0] send_index;
		logic        transmitting;
		logic        tx_busy;
	} tx_resp_t;

endpackage

`default_nettype wire

// ===== hdl/gtfu_store.sv =====
// ----------------------------------------------------------------------------
// gtfu_store
// receive byte memory, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module gtfu_store #(
	parameter int DEPTH = gtfu_pkg::RX_DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/gtfu_tx.sv =====
// ----------------------------------------------------------------------------
// gtfu_tx
// transmit sequencer: byte index hand-out with a guard timer
// ----------------------------------------------------------------------------
`default_nettype none

module gtfu_tx (
	input  logic              clk,
	input  logic              arst_n,
	input  gtfu_pkg::tx_cmd_t cmd,
	input  logic [7:0]        char_gap,
	output gtfu_pkg::tx_resp_t rsp
);
	import gtfu_pkg::*;

	logic [7:0]  timer_q, timer_d;
	logic [15:0] total_q, total_d;
	logic [15:0] pos_q, pos_d;
	logic        loaded_q, loaded_d;
	logic        irq_q, irq_d;
	logic        xmit_q, xmit_d;
	logic [1:0]  status;
	logic        send_valid;

	always_comb begin
		timer_d    = timer_q;
		total_d    = total_q;
		pos_d      = pos_q;
		loaded_d   = loaded_q;
		irq_d      = irq_q;
		xmit_d     = xmit_q;
		status     = ST_OK;
		send_valid = 1'b0;
		unique case (cmd.command)
			CMD_TICK: begin
				if (timer_q != 8'd0) begin
					timer_d = timer_q - 8'd1;
					// guard time ran out mid-transmission
					if (timer_q == 8'd1 && xmit_q) begin
						xmit_d   = 1'b0;
						irq_d    = 1'b0;
						pos_d    = '0;
						loaded_d = 1'b0;
					end
				end
			end
			CMD_START_TX: begin
				if (irq_q || xmit_q) begin
					status = ST_TRANSMITTING;
				end else if (cmd.tx_length != 16'd0) begin
					timer_d  = char_gap;
					loaded_d = 1'b1;
					total_d  = cmd.tx_length;
					pos_d    = '0;
					irq_d    = 1'b1;
					xmit_d   = 1'b1;
				end else begin
					status = ST_BAD_PARAM;
				end
			end
			CMD_TX_EMPTY: begin
				if (irq_q) begin
					if (loaded_q) begin
						if (pos_q < total_q) begin
							send_valid = 1'b1;
							pos_d      = pos_q + 16'd1;
							timer_d    = char_gap;
						end else begin
							irq_d  = 1'b0;
							xmit_d = 1'b0;
						end
					end else begin
						irq_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= '0;
			total_q  <= '0;
			pos_q    <= '0;
			loaded_q <= 1'b0;
			irq_q    <= 1'b0;
			xmit_q   <= 1'b0;
		end else if (cmd.fire) begin
			timer_q  <= timer_d;
			total_q  <= total_d;
			pos_q    <= pos_d;
			loaded_q <= loaded_d;
			irq_q    <= irq_d;
			xmit_q   <= xmit_d;
		end
	end

	assign rsp.status       = status;
	assign rsp.send_valid   = send_valid;
	assign rsp.send_index   = send_valid ? pos_q : 16'd0;
	assign rsp.transmitting = xmit_q;
	assign rsp.tx_busy      = irq_q | xmit_q;

endmodule

`default_nettype wire

// ===== hdl/gap_timed_frame_uart_buffer.sv =====
// ----------------------------------------------------------------------------
// gap_timed_frame_uart_buffer
// idle-gap framed uart receive buffer with a transmit index sequencer
// ----------------------------------------------------------------------------
//
//  channel    | handshake                      | payload
//  -----------+--------------------------------+-------------------------------
//  command    | start / busy                   | command, rx_byte, tx_length
//  result     | result_valid                   | status .. rx_state
//  config     | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
//  a single-result command gives its result in the cycle after the transaction
//  a read of a ready frame of n bytes streams n results, one per cycle from
//  the single read port of the byte memory; the first comes in the cycle after
//  the one a single result would use (memory read latency), and busy is held
//  high while the byte reads run; every other command leaves busy low
//  arst_n clears all control state; the byte memory needs no clearing pass
//  the receiver cannot stall results, so none are buffered
// ----------------------------------------------------------------------------
`default_nettype none

module gap_timed_frame_uart_buffer #(
	parameter int RX_DEPTH = gtfu_pkg::RX_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// command transaction
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] tx_length,
	// result strobe and fields
	output logic        result_valid,
	output logic [1:0]  status,
	output logic [7:0]  frame_byte,
	output logic        frame_byte_valid,
	output logic        last,
	output logic [6:0]  frame_length,
	output logic        frame_ready,
	output logic        send_valid,
	output logic [15:0] send_index,
	output logic        tx_busy,
	output logic [1:0]  rx_state,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import gtfu_pkg::*;

	localparam int AW = $clog2(RX_DEPTH);
	localparam int CW = $clog2(RX_DEPTH + 1);

	// readout sequencer codes
	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic          fire;
	logic [7:0]    char_gap_q, holdoff_q;

	// receive state
	logic [1:0]    rx_state_q, rx_state_d;
	logic [CW-1:0] count_q, count_d;
	logic [7:0]    rtimer_q, rtimer_d;
	logic [CW-1:0] ready_len_q, ready_len_d;
	logic          pend_q, pend_d;

	// per-command scratch values
	logic [CW-1:0] cnt_base;
	logic [1:0]    st_tmp;
	logic [CW-1:0] cnt_tmp;
	logic [1:0]    status_d;
	logic          fready_d;
	logic          read_go;

	// memory ports
	logic          we;
	logic [AW-1:0] waddr;
	logic          re;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;

	// readout sequencer
	logic          fsm_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] rd_len_q;
	logic          rd_valid_s1;
	logic          rd_last_s1;
	logic          rd_is_last;

	// single-result registers
	logic          single_q;
	logic [1:0]    status_q;
	logic          fready_q;
	logic          sv_q;
	logic [15:0]   sidx_q;

	tx_cmd_t       tx_cmd;
	tx_resp_t      tx_rsp;

	assign busy      = (fsm_q == S_READ);
	assign fire      = start && !busy;
	assign cfg_ready = 1'b1;

	// configuration registers; the user must write them only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_gap_q <= CHAR_GAP_RESET;
			holdoff_q  <= HOLDOFF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CHAR_GAP: char_gap_q <= cfg_data;
				CFG_HOLDOFF:  holdoff_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// transmit side
	assign tx_cmd.fire      = fire;
	assign tx_cmd.command   = command;
	assign tx_cmd.tx_length = tx_length;

	gtfu_tx u_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (tx_cmd),
		.char_gap (char_gap_q),
		.rsp      (tx_rsp)
	);

	// receive side command decode
	always_comb begin
		rx_state_d  = rx_state_q;
		count_d     = count_q;
		rtimer_d    = rtimer_q;
		ready_len_d = ready_len_q;
		pend_d      = pend_q;
		cnt_base    = count_q;
		st_tmp      = rx_state_q;
		cnt_tmp     = count_q;
		status_d    = ST_OK;
		fready_d    = 1'b0;
		read_go     = 1'b0;
		we          = 1'b0;
		waddr       = count_q[AW-1:0];
		unique case (command)
			CMD_RX_BYTE: begin
				// bytes while complete or ready are discarded
				if (rx_state_q == RS_IDLE || rx_state_q == RS_BUSY) begin
					cnt_base   = (rx_state_q == RS_IDLE) ? '0 : count_q;
					rx_state_d = RS_BUSY;
					rtimer_d   = char_gap_q;
					count_d    = cnt_base;
					// overflow drops the byte but still restarts the gap timer
					if (cnt_base < CW'(RX_DEPTH)) begin
						we      = fire;
						waddr   = cnt_base[AW-1:0];
						count_d = cnt_base + 1'b1;
					end
				end
			end
			CMD_TICK: begin
				if (rtimer_q != 8'd0) begin
					rtimer_d = rtimer_q - 8'd1;
					if (rtimer_q == 8'd1 && rx_state_q == RS_BUSY) begin
						rx_state_d = RS_COMPLETE;
					end
				end
			end
			CMD_LINE_ERROR: begin
				pend_d = 1'b1;
			end
			CMD_SCAN: begin
				// pending line error drops the frame and holds off
				if (pend_q) begin
					st_tmp   = RS_IDLE;
					rtimer_d = holdoff_q;
					cnt_tmp  = '0;
					pend_d   = 1'b0;
				end
				if (st_tmp == RS_COMPLETE) begin
					ready_len_d = cnt_tmp;
					st_tmp      = RS_READY;
					fready_d    = 1'b1;
				end
				rx_state_d = st_tmp;
				count_d    = cnt_tmp;
			end
			CMD_READ_FRAME: begin
				if (tx_rsp.transmitting) begin
					status_d = ST_TRANSMITTING;
				end else if (rx_state_q == RS_READY) begin
					ready_len_d = '0;
					rx_state_d  = RS_IDLE;
					// empty frame gives one result with no data
					read_go     = (ready_len_q != '0);
				end else begin
					status_d = ST_NOT_READY;
				end
			end
			CMD_START_TX, CMD_TX_EMPTY: begin
				status_d = tx_rsp.status;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_state_q  <= RS_IDLE;
			count_q     <= '0;
			rtimer_q    <= '0;
			ready_len_q <= '0;
			pend_q      <= 1'b0;
		end else if (fire) begin
			rx_state_q  <= rx_state_d;
			count_q     <= count_d;
			rtimer_q    <= rtimer_d;
			ready_len_q <= ready_len_d;
			pend_q      <= pend_d;
		end
	end

	// readout: one memory read per cycle, data out in the next cycle
	assign re         = (fsm_q == S_READ);
	assign raddr      = rd_idx_q[AW-1:0];
	assign rd_is_last = ((rd_idx_q + 1'b1) == rd_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_IDLE;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			single_q    <= 1'b0;
		end else begin
			rd_valid_s1 <= re;
			rd_last_s1  <= re && rd_is_last;
			single_q    <= fire && !read_go;
			unique case (fsm_q)
				S_IDLE: begin
					if (fire && read_go) begin
						fsm_q    <= S_READ;
						rd_idx_q <= '0;
					end
				end
				S_READ: begin
					if (rd_is_last) begin
						fsm_q <= S_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				default: begin
					fsm_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload registers
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			fready_q <= fready_d;
			sv_q     <= tx_rsp.send_valid;
			sidx_q   <= tx_rsp.send_index;
			if (read_go) begin
				rd_len_q <= ready_len_q;
			end
		end
	end

	gtfu_store #(
		.DEPTH (RX_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (rx_byte),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result ports; state fields show the registers after the step
	assign result_valid     = single_q || rd_valid_s1;
	assign status           = single_q ? status_q : ST_OK;
	assign frame_byte       = rd_valid_s1 ? rdata : 8'd0;
	assign frame_byte_valid = rd_valid_s1;
	assign last             = single_q || rd_last_s1;
	assign frame_length     = rd_valid_s1 ? 7'(rd_len_q) : 7'(ready_len_q);
	assign frame_ready      = single_q && fready_q;
	assign send_valid       = single_q && sv_q;
	assign send_index       = (single_q && sv_q) ? sidx_q : 16'd0;
	assign tx_busy          = tx_rsp.tx_busy;
	assign rx_state         = rx_state_q;

	// a streamed byte and a single result never share a cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		!(single_q && rd_valid_s1))
		else $error("single result collides with frame readout");

	// readout index stays inside the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == S_READ) |-> (rd_idx_q < rd_len_q))
		else $error("readout index beyond frame length");

	// fill count never passes the memory depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RX_DEPTH))
		else $error("receive count beyond depth");

	// no write to the memory while a readout runs
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !we)
		else $error("memory write during readout");

	// the last streamed byte ends the readout
	assert property (@(posedge clk) disable iff (!arst_n)
		(re && rd_is_last) |=> (fsm_q == S_IDLE) && rd_last_s1)
		else $error("readout did not end on last byte");

endmodule

`default_nettype wire

// ===== verif/tb_gap_timed_frame_uart_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_gap_timed_frame_uart_buffer
// self-checking bench for the gap-timed uart frame buffer: commands are sent
// in random bursts, a behavioural copy of the buffer predicts every result
// and a checker compares each strobed result field by field, in order
// ----------------------------------------------------------------------------

module tb_gap_timed_frame_uart_buffer;

	timeunit 1ns;
	timeprecision 1ps;

	import gtfu_pkg::*;

	localparam int          STORE_DEPTH = RX_DEPTH_DEFAULT;
	localparam int          CYCLE_LIMIT = 200000;
	localparam logic [2:0]  CMD_UNUSED  = 3'd7;   // no such command, answered with ok

	// one result as the block presents it
	typedef struct {
		logic [1:0]  status;
		logic [7:0]  frame_byte;
		logic        frame_byte_valid;
		logic        last;
		logic [6:0]  frame_length;
		logic        frame_ready;
		logic        send_valid;
		logic [15:0] send_index;
		logic        tx_busy;
		logic [1:0]  rx_state;
	} uart_result_t;

	// ports; the inputs are known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  command = CMD_RX_BYTE;
	logic [7:0]  rx_byte = 8'd0;
	logic [15:0] tx_length = 16'd0;
	logic        result_valid;
	logic [1:0]  status;
	logic [7:0]  frame_byte;
	logic        frame_byte_valid;
	logic        last;
	logic [6:0]  frame_length;
	logic        frame_ready;
	logic        send_valid;
	logic [15:0] send_index;
	logic        tx_busy;
	logic [1:0]  rx_state;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_CHAR_GAP;
	logic [7:0]  cfg_data = 8'd0;

	gap_timed_frame_uart_buffer dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.command          (command),
		.rx_byte          (rx_byte),
		.tx_length        (tx_length),
		.result_valid     (result_valid),
		.status           (status),
		.frame_byte       (frame_byte),
		.frame_byte_valid (frame_byte_valid),
		.last             (last),
		.frame_length     (frame_length),
		.frame_ready      (frame_ready),
		.send_valid       (send_valid),
		.send_index       (send_index),
		.tx_busy          (tx_busy),
		.rx_state         (rx_state),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// 20 ns clock
	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// behavioural copy of the buffer
	// ------------------------------------------------------------------------

	// register shadows
	logic [7:0]  gap_reg     = CHAR_GAP_RESET;
	logic [7:0]  holdoff_reg = HOLDOFF_RESET;

	// receive side
	logic [1:0]  rx_phase   = RS_IDLE;
	logic [6:0]  rx_fill    = '0;
	logic [7:0]  rx_mem [STORE_DEPTH];
	logic [6:0]  held_len   = '0;
	logic [7:0]  gap_count  = '0;
	logic        err_flag   = 1'b0;

	// transmit side
	logic [7:0]  guard_count  = '0;
	logic [15:0] tx_total_len = '0;
	logic [15:0] tx_next      = '0;
	logic        tx_armed     = 1'b0;
	logic        tx_irq       = 1'b0;
	logic        tx_active    = 1'b0;

	// results still owed by the block, oldest first
	uart_result_t results_due [$];

	int          fail_count  = 0;
	int          item_count  = 0;
	int          cycle_count = 0;

	// sender burst shaping
	int          burst_left = 0;
	bit          no_idle    = 1'b0;

	// one result; transmit and receive flags are taken after the command
	function automatic uart_result_t form_result(input logic [1:0] st, input logic [7:0] data,
			input logic data_valid, input logic is_last, input logic [6:0] flen,
			input logic fready, input logic sv, input logic [15:0] sidx);
		uart_result_t r;
		r.status           = st;
		r.frame_byte       = data;
		r.frame_byte_valid = data_valid;
		r.last             = is_last;
		r.frame_length     = flen;
		r.frame_ready      = fready;
		r.send_valid       = sv;
		r.send_index       = sidx;
		r.tx_busy          = tx_irq | tx_active;
		r.rx_state         = rx_phase;
		return r;
	endfunction

	// advance the copy by one accepted command and queue what it owes
	task automatic frame_buffer_step(input logic [2:0] cmd, input logic [7:0] data,
			input logic [15:0] len);
		logic [1:0]  st;
		logic        fready;
		logic        sv;
		logic [15:0] sidx;
		int          n;
		st     = ST_OK;
		fready = 1'b0;
		sv     = 1'b0;
		sidx   = '0;
		case (cmd)
			CMD_RX_BYTE: begin
				// bytes are taken only while idle or busy
				if (rx_phase == RS_IDLE || rx_phase == RS_BUSY) begin
					if (rx_phase == RS_IDLE) begin
						rx_phase = RS_BUSY;
						rx_fill  = '0;
					end
					// overflow drops the byte but still restarts the gap
					if (rx_fill < STORE_DEPTH) begin
						rx_mem[rx_fill[5:0]] = data;
						rx_fill++;
					end
					gap_count = gap_reg;
				end
			end
			CMD_TICK: begin
				if (guard_count != 0) begin
					guard_count--;
					if (guard_count == 0 && tx_active) begin
						tx_active = 1'b0;
						tx_irq    = 1'b0;
						tx_next   = '0;
						tx_armed  = 1'b0;
					end
				end
				if (gap_count != 0) begin
					gap_count--;
					if (gap_count == 0 && rx_phase == RS_BUSY)
						rx_phase = RS_COMPLETE;
				end
			end
			CMD_LINE_ERROR: begin
				err_flag = 1'b1;
			end
			CMD_SCAN: begin
				if (err_flag) begin
					rx_phase  = RS_IDLE;
					gap_count = holdoff_reg;
					rx_fill   = '0;
					err_flag  = 1'b0;
				end
				if (rx_phase == RS_COMPLETE) begin
					held_len = rx_fill;
					rx_phase = RS_READY;
					fready   = 1'b1;
				end
			end
			CMD_READ_FRAME: begin
				if (tx_active) begin
					st = ST_TRANSMITTING;
				end else if (rx_phase == RS_READY) begin
					n        = (held_len > STORE_DEPTH) ? STORE_DEPTH : held_len;
					held_len = '0;
					rx_phase = RS_IDLE;
					if (n == 0) begin
						results_due.push_back(form_result(ST_OK, 8'd0, 1'b0, 1'b1, 7'd0,
							1'b0, 1'b0, 16'd0));
						return;
					end
					for (int i = 0; i < n; i++)
						results_due.push_back(form_result(ST_OK, rx_mem[i], 1'b1, i == n - 1,
							7'(n), 1'b0, 1'b0, 16'd0));
					return;
				end else begin
					st = ST_NOT_READY;
				end
			end
			CMD_START_TX: begin
				if (tx_irq || tx_active) begin
					st = ST_TRANSMITTING;
				end else if (len != 0) begin
					guard_count  = gap_reg;
					tx_armed     = 1'b1;
					tx_total_len = len;
					tx_next      = '0;
					tx_irq       = 1'b1;
					tx_active    = 1'b1;
				end else begin
					st = ST_BAD_PARAM;
				end
			end
			CMD_TX_EMPTY: begin
				if (tx_irq) begin
					if (tx_armed) begin
						if (tx_next < tx_total_len) begin
							sv          = 1'b1;
							sidx        = tx_next;
							tx_next++;
							guard_count = gap_reg;
						end else begin
							tx_irq    = 1'b0;
							tx_active = 1'b0;
						end
					end else begin
						tx_irq = 1'b0;
					end
				end
			end
			default: ;
		endcase
		results_due.push_back(form_result(st, 8'd0, 1'b0, 1'b1, held_len, fready, sv, sidx));
	endtask

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	// one command transaction; bursts of random length with random gaps between
	task automatic issue_command(input logic [2:0] cmd, input logic [7:0] data,
			input logic [15:0] len);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap        = no_idle ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		start     <= 1'b1;
		command   <= cmd;
		rx_byte   <= data;
		tx_length <= len;
		// accepted at the first edge with busy low
		do @(posedge clk); while (busy);
		frame_buffer_step(cmd, data, len);
		item_count++;
	endtask

	// junk in the unused fields keeps every input bit moving
	task automatic issue_plain(input logic [2:0] cmd);
		issue_command(cmd, 8'($urandom), 16'($urandom));
	endtask

	task automatic issue_ticks(input int count);
		repeat (count) issue_plain(CMD_TICK);
	endtask

	// let every owed result drain before touching the registers
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [7:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CHAR_GAP: gap_reg     = value;
			CFG_HOLDOFF:  holdoff_reg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// test tasks
	// ------------------------------------------------------------------------

	// frame assembly, completion by gap, promotion and readout
	task automatic test_receive_frames();
		issue_plain(CMD_READ_FRAME);              // nothing ready yet
		issue_command(CMD_RX_BYTE, 8'h00, 16'hFFFF);
		issue_command(CMD_RX_BYTE, 8'hFF, 16'h0000);
		issue_command(CMD_RX_BYTE, 8'hA5, 16'h5A5A);
		issue_ticks(gap_reg);                      // gap expires, frame complete
		issue_command(CMD_RX_BYTE, 8'h3C, 16'd0);  // discarded while complete
		issue_plain(CMD_READ_FRAME);              // complete is not yet ready
		issue_plain(CMD_SCAN);
		issue_plain(CMD_SCAN);                    // second scan promotes nothing
		issue_command(CMD_RX_BYTE, 8'hC3, 16'd0);  // discarded while ready
		issue_plain(CMD_READ_FRAME);
		issue_plain(CMD_READ_FRAME);              // frame already handed out
		issue_plain(CMD_UNUSED);
	endtask

	// a line error drops the partial frame and loads the holdoff time
	task automatic test_line_errors();
		issue_command(CMD_RX_BYTE, 8'h11, 16'd0);
		issue_command(CMD_RX_BYTE, 8'h22, 16'd0);
		issue_plain(CMD_LINE_ERROR);
		issue_plain(CMD_SCAN);
		issue_ticks(2);
		issue_command(CMD_RX_BYTE, 8'h5A, 16'd0);
		issue_ticks(gap_reg);
		issue_plain(CMD_LINE_ERROR);
		issue_plain(CMD_SCAN);                    // error wins over the complete frame
		issue_plain(CMD_READ_FRAME);
	endtask

	// index sequencing, refusals and the guard timeout
	task automatic test_transmit();
		issue_command(CMD_START_TX, 8'd0, 16'd0);      // zero length refused
		issue_plain(CMD_TX_EMPTY);                     // interrupt off, ignored
		issue_command(CMD_START_TX, 8'd0, 16'd3);
		issue_command(CMD_START_TX, 8'd0, 16'd9);      // already transmitting
		issue_plain(CMD_READ_FRAME);                   // refused while transmitting
		repeat (4) issue_plain(CMD_TX_EMPTY);          // three indexes then release
		issue_plain(CMD_TX_EMPTY);
		issue_command(CMD_START_TX, 8'd0, 16'hFFFF);
		repeat (2) issue_plain(CMD_TX_EMPTY);
		issue_ticks(gap_reg);                          // guard runs out
		issue_plain(CMD_TX_EMPTY);
	endtask

	// register extremes: no gap, longest gap, shortest gap
	task automatic test_register_extremes();
		write_register(CFG_CHAR_GAP, 8'd0);
		write_register(CFG_HOLDOFF, 8'd0);
		issue_command(CMD_RX_BYTE, 8'h81, 16'd0);
		issue_ticks(3);                                // no gap, frame stays busy
		issue_command(CMD_START_TX, 8'd0, 16'd2);
		issue_ticks(3);                                // and no guard either
		repeat (3) issue_plain(CMD_TX_EMPTY);
		issue_plain(CMD_LINE_ERROR);
		issue_plain(CMD_SCAN);
		issue_plain(CMD_READ_FRAME);

		write_register(CFG_CHAR_GAP, 8'd255);
		write_register(CFG_HOLDOFF, 8'd255);
		issue_command(CMD_RX_BYTE, 8'h7E, 16'd0);
		issue_command(CMD_RX_BYTE, 8'hE7, 16'd0);
		issue_ticks(4);                                // long gap, frame still busy
		issue_plain(CMD_LINE_ERROR);
		issue_plain(CMD_SCAN);                         // frame dropped, long holdoff
		issue_plain(CMD_READ_FRAME);

		write_register(CFG_CHAR_GAP, 8'd1);
		issue_command(CMD_RX_BYTE, 8'h42, 16'd0);
		issue_ticks(1);
		issue_plain(CMD_SCAN);
		issue_plain(CMD_READ_FRAME);
	endtask

	// bytes beyond the store depth are dropped, the rest read back in full
	task automatic test_overflow();
		write_register(CFG_CHAR_GAP, 8'($urandom_range(1, 3)));
		no_idle = 1'b1;
		repeat (STORE_DEPTH + $urandom_range(2, 6))
			issue_command(CMD_RX_BYTE, 8'($urandom), 16'($urandom));
		no_idle = 1'b0;
		issue_ticks(gap_reg);
		issue_plain(CMD_SCAN);
		issue_plain(CMD_READ_FRAME);
	endtask

	// a frame, mostly well formed; a few are cut short or hit by a line error
	task automatic random_frame();
		int nbytes;
		int nticks;
		nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
		for (int i = 0; i < nbytes; i++) begin
			issue_command(CMD_RX_BYTE, 8'($urandom), 16'($urandom));
			if ($urandom_range(0, 29) == 0)
				issue_plain(CMD_LINE_ERROR);
		end
		nticks = gap_reg + $urandom_range(0, 2);
		if ($urandom_range(0, 7) == 0)
			nticks = $urandom_range(0, gap_reg);
		issue_ticks(nticks);
		if ($urandom_range(0, 11) == 0)
			issue_plain(CMD_LINE_ERROR);
		issue_plain(CMD_SCAN);
		if ($urandom_range(0, 5) == 0)
			issue_plain(CMD_SCAN);
		issue_plain(CMD_READ_FRAME);
	endtask

	// a transmission, sometimes abandoned to the guard timer
	task automatic random_transmission();
		int len;
		int empties;
		len = $urandom_range(1, 6);
		issue_command(CMD_START_TX, 8'($urandom), 16'(len));
		if ($urandom_range(0, 3) == 0)
			issue_command(CMD_START_TX, 8'($urandom), 16'($urandom));
		empties = $urandom_range(0, len + 1);
		for (int i = 0; i < empties; i++) begin
			issue_plain(CMD_TX_EMPTY);
			if ($urandom_range(0, 7) == 0)
				issue_plain(CMD_READ_FRAME);
		end
		issue_ticks(gap_reg);
	endtask

	task automatic random_noise();
		repeat ($urandom_range(1, 4))
			issue_plain(3'($urandom_range(0, 7)));
	endtask

	// several register settings, each with a stretch of mixed traffic
	task automatic test_random_traffic();
		int phase_end;
		int pick;
		for (int phase = 0; phase < 4; phase++) begin
			write_register(CFG_CHAR_GAP, 8'($urandom_range(1, 8)));
			write_register(CFG_HOLDOFF, 8'($urandom_range(0, 12)));
			no_idle   = (phase == 2);
			phase_end = item_count + 36;
			while (item_count < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					random_frame();
				else if (pick < 85)
					random_transmission();
				else
					random_noise();
			end
		end
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// result checker: every strobe is matched against the oldest owed result
	// ------------------------------------------------------------------------
	uart_result_t owed;

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (result_valid) begin
			if (results_due.size() == 0) begin
				$display("%0t ns: result with nothing owed, status %0d", $time, status);
				fail_count++;
			end else begin
				owed = results_due.pop_front();
				compare_field("status", owed.status, status);
				compare_field("frame_byte", owed.frame_byte, frame_byte);
				compare_field("frame_byte_valid", owed.frame_byte_valid, frame_byte_valid);
				compare_field("last", owed.last, last);
				compare_field("frame_length", owed.frame_length, frame_length);
				compare_field("frame_ready", owed.frame_ready, frame_ready);
				compare_field("send_valid", owed.send_valid, send_valid);
				compare_field("send_index", owed.send_index, send_index);
				compare_field("tx_busy", owed.tx_busy, tx_busy);
				compare_field("rx_state", owed.rx_state, rx_state);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_gap_timed_frame_uart_buffer: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		// reset held low first, then released away from the sampling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_receive_frames();
		test_line_errors();
		test_transmit();
		test_register_extremes();
		test_overflow();
		test_random_traffic();

		// let the last transactions come back, then a short settling margin
		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_gap_timed_frame_uart_buffer: PASS");
		else
			$display("tb_gap_timed_frame_uart_buffer: FAIL");
		$finish;
	end

endmodule
